// ----- rtl/core/spdt_pkg.sv -----
package spdt_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_DEADBAND       = 3'd0;
    localparam logic [2:0] REG_STEP_DEG       = 3'd1;
    localparam logic [2:0] REG_FRAME_CENTER_X = 3'd2;
    localparam logic [2:0] REG_PERIOD_US      = 3'd3;
    localparam logic [2:0] REG_PULSE_OFFSET   = 3'd4;
    localparam logic [2:0] REG_PULSE_GAIN     = 3'd5;
    localparam logic [2:0] REG_FULL_SWING     = 3'd6;
    localparam logic [2:0] REG_HOME_ANGLE     = 3'd7;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_HOME   = 2'd2;

    // Register reset values.
    localparam logic [11:0] DEADBAND_RST       = 12'd20;
    localparam logic [7:0]  STEP_DEG_RST       = 8'd3;
    localparam logic [11:0] FRAME_CENTER_RST   = 12'd640;
    localparam logic [15:0] PERIOD_US_RST      = 16'd20000;
    localparam logic [15:0] PULSE_OFFSET_RST   = 16'd546;
    localparam logic [9:0]  PULSE_GAIN_RST     = 10'd103;
    localparam logic [7:0]  FULL_SWING_RST     = 8'd40;
    localparam logic [7:0]  HOME_ANGLE_RST     = 8'd90;
    localparam logic [7:0]  PAN_ANGLE_RST      = 8'd90;

    // Exact floor division of an 18-bit product by ten: (p * HT_MUL) >> HT_SHIFT.
    localparam int unsigned HT_SHIFT = 22;
    localparam logic [18:0] HT_MUL   = 19'd419431;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned M_DATA_W   = 16;

endpackage

// ----- rtl/core/servo_pan_deadband_tracker_unit.sv -----
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  one item: mode in tuser, face_x in tdata
// m_*       out        m_tvalid/m_tready  one result per item
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// An item enters the input register, is worked on combinationally and lands in
// the result register, so ticks and dropped commands flow at one item per cycle
// while m_tready is high. A command that queues servo periods holds the next item
// while the pulse-count and high-time pipeline (four multipliers) finishes.
// rst_n clears all but the payload registers; while m_tready is low the result
// register holds its item, the input register takes one more, then s_tready falls.
module servo_pan_deadband_tracker_unit
    import spdt_pkg::*;
#(
    parameter int ANGLE_MAX  = 180,
    parameter int COORD_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // face_x in the low COORD_BITS bits, zero padding above
    input  logic [((COORD_BITS+7)/8)*8-1:0] s_tdata,
    // mode in bits 1:0
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // servo_out [0], angle_now [8:1], busy_res [9], accepted [10], zeros above
    output logic [M_DATA_W-1:0]             m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    localparam int CMP_W     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
    localparam int CNT_SHIFT = 16 + $clog2(ANGLE_MAX);
    localparam logic [17:0] CNT_MUL =
        18'(((64'd1 << CNT_SHIFT) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX));
    localparam logic [7:0] AMAX = 8'(ANGLE_MAX);

    // Configuration registers.
    logic [11:0] deadband_reg;
    logic [7:0]  step_deg_reg;
    logic [11:0] center_reg;
    logic [15:0] period_reg;
    logic [15:0] offset_reg;
    logic [9:0]  gain_reg;
    logic [7:0]  swing_reg;
    logic [7:0]  home_reg;

    // Tracker state.
    logic [7:0]  pan_reg, pan_next;
    logic [7:0]  pulses_reg, pulses_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] ht_reg, ht_next;

    // Input register.
    logic                  in_valid_reg;
    logic [1:0]            mode_reg;
    logic [COORD_BITS-1:0] x_reg;

    // Result register.
    logic       out_valid_reg;
    logic       servo_reg, servo_next;
    logic [7:0] angle_out_reg;
    logic       busy_reg;
    logic       acc_reg, acc_next;

    // Pulse-count and high-time pipeline.
    logic [2:0]  calc_v_reg;
    logic [7:0]  c1_dist_reg, c1_fs_reg, c1_ang_reg;
    logic [9:0]  c1_gain_reg;
    logic [15:0] c1_off_reg, c1_per_reg;
    logic [15:0] c2_n_reg;
    logic [17:0] c2_p_reg;
    logic [15:0] c2_off_reg, c2_per_reg;
    logic [15:0] c3_qc_reg;
    logic [14:0] c3_qh_reg;
    logic [15:0] c3_off_reg, c3_per_reg;

    logic        adv, s_accept, launch, move;
    logic [15:0] eperiod, pc_inc;
    logic [CMP_W-1:0] x_ext, lim_hi, lim_lo;
    logic        right, left;
    logic [8:0]  up_sum;
    logic [7:0]  up_ang, dn_ang, home_ang, new_ang, move_dist;
    logic [33:0] cnt_prod;
    logic [36:0] ht_prod;
    logic [7:0]  cnt_final;
    logic [16:0] ht_sum;
    logic [15:0] ht_final;

    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready) && (calc_v_reg == 3'b000);
    assign s_tready  = !in_valid_reg || adv;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, acc_reg, busy_reg, angle_out_reg, servo_reg};

    assign eperiod = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign pc_inc  = pc_reg + 16'd1;

    // Deadband test, kept unsigned by moving the deadband to the other side.
    assign x_ext  = CMP_W'(x_reg);
    assign lim_hi = CMP_W'(center_reg) + CMP_W'(deadband_reg);
    assign lim_lo = x_ext + CMP_W'(deadband_reg);
    assign right  = x_ext > lim_hi;
    assign left   = lim_lo < CMP_W'(center_reg);

    assign up_sum   = {1'b0, pan_reg} + {1'b0, step_deg_reg};
    assign up_ang   = (up_sum > {1'b0, AMAX}) ? AMAX : up_sum[7:0];
    assign dn_ang   = (pan_reg >= step_deg_reg) ? (pan_reg - step_deg_reg) : 8'd0;
    assign home_ang = (home_reg > AMAX) ? AMAX : home_reg;

    always_comb
    begin
        pan_next    = pan_reg;
        pulses_next = pulses_reg;
        pc_next     = pc_reg;
        ht_next     = ht_reg;
        servo_next  = 1'b0;
        acc_next    = 1'b0;
        move        = 1'b0;
        new_ang     = pan_reg;
        unique case (mode_reg)
            MODE_TICK:
            begin
                if (pulses_reg != 8'd0)
                begin
                    servo_next = pc_reg < ht_reg;
                    if (pc_inc >= eperiod)
                    begin
                        pc_next     = 16'd0;
                        pulses_next = pulses_reg - 8'd1;
                    end
                    else
                    begin
                        pc_next = pc_inc;
                    end
                end
            end
            MODE_SAMPLE:
            begin
                if (pulses_reg == 8'd0)
                begin
                    acc_next = 1'b1;
                    if (right)
                    begin
                        move    = 1'b1;
                        new_ang = up_ang;
                    end
                    else if (left)
                    begin
                        move    = 1'b1;
                        new_ang = dn_ang;
                    end
                end
            end
            MODE_HOME:
            begin
                if (pulses_reg == 8'd0)
                begin
                    acc_next = 1'b1;
                    move     = 1'b1;
                    new_ang  = home_ang;
                end
            end
            default:
            begin
            end
        endcase

        // A home command queues ceil(ANGLE_MAX * swing / ANGLE_MAX) = swing periods.
        if (mode_reg == MODE_HOME)
            move_dist = AMAX;
        else
            move_dist = (new_ang > pan_reg) ? (new_ang - pan_reg) : (pan_reg - new_ang);

        launch = move && (move_dist != 8'd0) && (swing_reg != 8'd0);
        if (move)
        begin
            pan_next = new_ang;
            pc_next  = 16'd0;
            // Holds busy until the pipeline writes the exact count.
            pulses_next = launch ? 8'd1 : 8'd0;
        end
    end

    assign cnt_prod  = 34'(c2_n_reg) * 34'(CNT_MUL);
    assign ht_prod   = 37'(c2_p_reg) * 37'(HT_MUL);
    assign cnt_final = (c3_qc_reg > 16'd255) ? 8'd255 : c3_qc_reg[7:0];
    assign ht_sum    = {1'b0, c3_off_reg} + {2'b00, c3_qh_reg};
    assign ht_final  = (ht_sum > {1'b0, c3_per_reg}) ? c3_per_reg : ht_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            step_deg_reg  <= STEP_DEG_RST;
            center_reg    <= FRAME_CENTER_RST;
            period_reg    <= PERIOD_US_RST;
            offset_reg    <= PULSE_OFFSET_RST;
            gain_reg      <= PULSE_GAIN_RST;
            swing_reg     <= FULL_SWING_RST;
            home_reg      <= HOME_ANGLE_RST;
            pan_reg       <= PAN_ANGLE_RST;
            pulses_reg    <= 8'd0;
            pc_reg        <= 16'd0;
            ht_reg        <= 16'd0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            calc_v_reg    <= 3'b000;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_DEADBAND:       deadband_reg <= cfg_data[11:0];
                    REG_STEP_DEG:       step_deg_reg <= cfg_data[7:0];
                    REG_FRAME_CENTER_X: center_reg   <= cfg_data[11:0];
                    REG_PERIOD_US:      period_reg   <= cfg_data;
                    REG_PULSE_OFFSET:   offset_reg   <= cfg_data;
                    REG_PULSE_GAIN:     gain_reg     <= cfg_data[9:0];
                    REG_FULL_SWING:     swing_reg    <= cfg_data[7:0];
                    REG_HOME_ANGLE:     home_reg     <= cfg_data[7:0];
                    default:            ;
                endcase
            end

            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv)
            begin
                out_valid_reg <= 1'b1;
                pan_reg       <= pan_next;
                pulses_reg    <= pulses_next;
                pc_reg        <= pc_next;
                ht_reg        <= ht_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            calc_v_reg <= {calc_v_reg[1:0], adv && launch};

            // The stage-2 path is held while the pipeline runs, so no write clash.
            if (calc_v_reg[2])
            begin
                pulses_reg <= cnt_final;
                ht_reg     <= ht_final;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg <= s_tuser;
            x_reg    <= s_tdata[COORD_BITS-1:0];
        end
        if (adv)
        begin
            servo_reg     <= servo_next;
            angle_out_reg <= pan_next;
            busy_reg      <= pulses_next != 8'd0;
            acc_reg       <= acc_next;
            c1_dist_reg   <= move_dist;
            c1_fs_reg     <= swing_reg;
            c1_ang_reg    <= new_ang;
            c1_gain_reg   <= gain_reg;
            c1_off_reg    <= offset_reg;
            c1_per_reg    <= eperiod;
        end
        c2_n_reg   <= 16'(16'(c1_dist_reg) * 16'(c1_fs_reg)) + 16'(ANGLE_MAX - 1);
        c2_p_reg   <= 18'(c1_gain_reg) * 18'(c1_ang_reg);
        c2_off_reg <= c1_off_reg;
        c2_per_reg <= c1_per_reg;
        c3_qc_reg  <= 16'(cnt_prod >> CNT_SHIFT);
        c3_qh_reg  <= ht_prod[36:HT_SHIFT];
        c3_off_reg <= c2_off_reg;
        c3_per_reg <= c2_per_reg;
    end

endmodule
